### rtl/rmssp_pkg.sv
`timescale 1ns / 1ps

package rmssp_pkg;

    localparam int SYNC_DEADBAND_COUNTS = 5;
    localparam int MASTER_DEADBAND      = 10;
    localparam int MASTER_I_LIMIT       = 1000;
    localparam int SLAVE_I_LIMIT        = 500;
    localparam int DUTY_MAX             = 255;
    localparam int SLAVE_DRIVE_MAX      = 32767;
    localparam int SLAVE_DRIVE_MIN      = -32768;

    localparam logic [7:0]  CRUISE_LIMIT_RESET = 8'd255;
    localparam logic [15:0] RAMP_RATE_RESET    = 16'd256;

    typedef enum logic [1:0] {
        FUNC_TICK       = 2'd0,
        FUNC_SET_TARGET = 2'd1,
        FUNC_ZERO       = 2'd2,
        FUNC_HALT       = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        REG_MASTER_KP    = 3'd0,
        REG_MASTER_KI    = 3'd1,
        REG_MASTER_KD    = 3'd2,
        REG_SLAVE_KP     = 3'd3,
        REG_SLAVE_KI     = 3'd4,
        REG_SLAVE_KD     = 3'd5,
        REG_CRUISE_LIMIT = 3'd6,
        REG_RAMP_RATE    = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        func_t              func;
        logic [15:0]        elapsed_ms;
        logic signed [31:0] master_pos;
        logic signed [31:0] slave_pos;
        logic signed [31:0] new_target;
        logic               immediate;
    } in_item_t;

    typedef struct packed {
        logic signed [8:0]  master_drive;
        logic [7:0]         master_duty;
        logic               master_dir;
        logic               master_enable;
        logic signed [15:0] slave_drive;
        logic [7:0]         slave_duty;
        logic               slave_dir;
        logic               slave_enable;
        logic signed [31:0] ramp_target;
    } out_item_t;

    // q8.8 product scaled to whole units, truncated toward zero
    function automatic logic signed [41:0] q8_trunc(input logic signed [49:0] p);
        return 42'(p[49:8]) + 42'(p[49] && (p[7:0] != 8'h00));
    endfunction

endpackage

### rtl/ramped_master_slave_sync_pid.sv
// throughput: one item per cycle unless m_ready back-pressure stalls the pipeline
// stages are input, pid terms, gain products, output
// set target, zero and halt update state only; unsynced ticks produce nothing
// reset (aresetn low, synchronous): empty pipeline, unsynced, state cleared,
// gains 0, cruise limit 255, ramp rate 256
`timescale 1ns / 1ps

module ramped_master_slave_sync_pid (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rmssp_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rmssp_pkg::out_item_t m_data
);

    // configuration
    logic signed [15:0] cfg_master_kp_reg, cfg_master_ki_reg, cfg_master_kd_reg;
    logic signed [15:0] cfg_slave_kp_reg, cfg_slave_ki_reg, cfg_slave_kd_reg;
    logic [7:0]         cfg_cruise_reg;
    logic [15:0]        cfg_ramp_rate_reg;

    // loop state
    logic               synced_reg, synced_next;
    logic signed [31:0] final_target_reg, final_target_next;
    logic signed [39:0] setpoint_reg, setpoint_next;
    logic signed [10:0] m_int_reg, m_int_next;
    logic signed [32:0] m_last_reg, m_last_next;
    logic signed [9:0]  s_int_reg, s_int_next;
    logic signed [32:0] s_last_reg, s_last_next;

    // pipeline
    logic                in_valid_reg;
    rmssp_pkg::in_item_t in_item_reg;
    logic [31:0]         in_step_reg;
    logic                t_valid_reg;
    logic signed [32:0]  t_m_err_reg, t_s_err_reg;
    logic signed [10:0]  t_m_int_reg;
    logic signed [9:0]   t_s_int_reg;
    logic signed [33:0]  t_m_diff_reg, t_s_diff_reg;
    logic signed [31:0]  t_tpos_reg;
    logic                p_valid_reg;
    logic signed [40:0]  p_m_e_reg, p_s_e_reg;
    logic signed [18:0]  p_m_i_reg;
    logic signed [17:0]  p_s_i_reg;
    logic signed [41:0]  p_m_d_reg, p_s_d_reg;
    logic signed [31:0]  p_tpos_reg;
    logic                m_valid_reg;
    rmssp_pkg::out_item_t m_data_reg, m_data_next;

    logic out_en, p_en, t_en, in_en;

    assign out_en  = !m_valid_reg || m_ready;
    assign p_en    = !p_valid_reg || out_en;
    assign t_en    = !t_valid_reg || p_en;
    assign in_en   = !in_valid_reg || t_en;
    assign s_ready = in_en;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_master_kp_reg <= '0;
            cfg_master_ki_reg <= '0;
            cfg_master_kd_reg <= '0;
            cfg_slave_kp_reg  <= '0;
            cfg_slave_ki_reg  <= '0;
            cfg_slave_kd_reg  <= '0;
            cfg_cruise_reg    <= rmssp_pkg::CRUISE_LIMIT_RESET;
            cfg_ramp_rate_reg <= rmssp_pkg::RAMP_RATE_RESET;
        end else if (cfg_wr_en) begin
            unique case (rmssp_pkg::cfg_reg_t'(cfg_index))
                rmssp_pkg::REG_MASTER_KP:    cfg_master_kp_reg <= cfg_wr_data;
                rmssp_pkg::REG_MASTER_KI:    cfg_master_ki_reg <= cfg_wr_data;
                rmssp_pkg::REG_MASTER_KD:    cfg_master_kd_reg <= cfg_wr_data;
                rmssp_pkg::REG_SLAVE_KP:     cfg_slave_kp_reg  <= cfg_wr_data;
                rmssp_pkg::REG_SLAVE_KI:     cfg_slave_ki_reg  <= cfg_wr_data;
                rmssp_pkg::REG_SLAVE_KD:     cfg_slave_kd_reg  <= cfg_wr_data;
                rmssp_pkg::REG_CRUISE_LIMIT: cfg_cruise_reg    <= cfg_wr_data[7:0];
                rmssp_pkg::REG_RAMP_RATE:    cfg_ramp_rate_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // input stage: ramp step for this item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_en) begin
            in_valid_reg <= s_valid;
        end
        if (in_en) begin
            in_item_reg <= s_data;
            in_step_reg <= 32'(cfg_ramp_rate_reg) * 32'(s_data.elapsed_ms);
        end
    end

    // ramp and error terms
    logic signed [40:0] sp_final;
    logic signed [40:0] sp_gap, sp_gap_neg;
    logic [40:0]        sp_gap_mag;
    logic               in_reach;
    logic signed [39:0] sp_tick;
    logic signed [31:0] tpos;
    logic signed [32:0] m_err_raw, m_err, s_err_raw, s_err;
    logic               m_band, s_band;
    logic signed [33:0] m_int_sum, s_int_sum;
    logic signed [10:0] m_int_new;
    logic signed [9:0]  s_int_new;
    logic signed [33:0] m_diff, s_diff;

    always_comb begin
        sp_final   = 41'($signed({final_target_reg, 8'h00}));
        sp_gap     = sp_final - 41'(setpoint_reg);
        sp_gap_neg = -sp_gap;
        sp_gap_mag = sp_gap[40] ? sp_gap_neg : sp_gap;
        in_reach   = sp_gap_mag <= 41'(in_step_reg);
        if (in_reach) begin
            sp_tick = sp_final[39:0];
        end else if (!sp_gap[40]) begin
            sp_tick = setpoint_reg + 40'(in_step_reg);
        end else begin
            sp_tick = setpoint_reg - 40'(in_step_reg);
        end
        tpos = sp_tick[39:8] + 32'(sp_tick[39] && (sp_tick[7:0] != 8'h00));

        m_err_raw = 33'(tpos) - 33'(in_item_reg.master_pos);
        m_band    = (m_err_raw > -rmssp_pkg::MASTER_DEADBAND)
                 && (m_err_raw < rmssp_pkg::MASTER_DEADBAND);
        m_err     = m_band ? '0 : m_err_raw;
        m_int_sum = 34'(m_int_reg) + 34'(m_err);
        if (m_band) begin
            m_int_new = '0;
        end else if (m_int_sum > rmssp_pkg::MASTER_I_LIMIT) begin
            m_int_new = 11'(rmssp_pkg::MASTER_I_LIMIT);
        end else if (m_int_sum < -rmssp_pkg::MASTER_I_LIMIT) begin
            m_int_new = 11'(-rmssp_pkg::MASTER_I_LIMIT);
        end else begin
            m_int_new = m_int_sum[10:0];
        end
        m_diff = 34'(m_err) - 34'(m_last_reg);

        s_err_raw = 33'(in_item_reg.master_pos) - 33'(in_item_reg.slave_pos);
        s_band    = (s_err_raw > -rmssp_pkg::SYNC_DEADBAND_COUNTS)
                 && (s_err_raw < rmssp_pkg::SYNC_DEADBAND_COUNTS);
        s_err     = s_band ? '0 : s_err_raw;
        s_int_sum = 34'(s_int_reg) + 34'(s_err);
        if (s_band) begin
            s_int_new = '0;
        end else if (s_int_sum > rmssp_pkg::SLAVE_I_LIMIT) begin
            s_int_new = 10'(rmssp_pkg::SLAVE_I_LIMIT);
        end else if (s_int_sum < -rmssp_pkg::SLAVE_I_LIMIT) begin
            s_int_new = 10'(-rmssp_pkg::SLAVE_I_LIMIT);
        end else begin
            s_int_new = s_int_sum[9:0];
        end
        s_diff = 34'(s_err) - 34'(s_last_reg);
    end

    // state update
    always_comb begin
        synced_next       = synced_reg;
        final_target_next = final_target_reg;
        setpoint_next     = setpoint_reg;
        m_int_next        = m_int_reg;
        m_last_next       = m_last_reg;
        s_int_next        = s_int_reg;
        s_last_next       = s_last_reg;
        if (in_valid_reg && t_en) begin
            unique case (in_item_reg.func)
                rmssp_pkg::FUNC_TICK: begin
                    if (synced_reg) begin
                        setpoint_next = sp_tick;
                        m_int_next    = m_int_new;
                        m_last_next   = m_err;
                        s_int_next    = s_int_new;
                        s_last_next   = s_err;
                    end
                end
                rmssp_pkg::FUNC_SET_TARGET: begin
                    final_target_next = in_item_reg.new_target;
                    if (in_item_reg.immediate) begin
                        setpoint_next = $signed({in_item_reg.new_target, 8'h00});
                    end else if (!synced_reg) begin
                        setpoint_next = $signed({in_item_reg.master_pos, 8'h00});
                    end
                    synced_next = 1'b1;
                end
                rmssp_pkg::FUNC_ZERO: begin
                    final_target_next = '0;
                    setpoint_next     = '0;
                    m_int_next        = '0;
                    m_last_next       = '0;
                    s_int_next        = '0;
                    s_last_next       = '0;
                    synced_next       = 1'b1;
                end
                rmssp_pkg::FUNC_HALT: begin
                    final_target_next = in_item_reg.master_pos;
                    setpoint_next     = $signed({in_item_reg.master_pos, 8'h00});
                    synced_next       = 1'b1;
                end
                default: ;
            endcase
        end
        // gain writes restart the matching loop
        if (cfg_wr_en) begin
            unique case (rmssp_pkg::cfg_reg_t'(cfg_index))
                rmssp_pkg::REG_MASTER_KP, rmssp_pkg::REG_MASTER_KI,
                rmssp_pkg::REG_MASTER_KD: begin
                    m_int_next  = '0;
                    m_last_next = '0;
                end
                rmssp_pkg::REG_SLAVE_KP, rmssp_pkg::REG_SLAVE_KI,
                rmssp_pkg::REG_SLAVE_KD: begin
                    s_int_next  = '0;
                    s_last_next = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            synced_reg       <= 1'b0;
            final_target_reg <= '0;
            setpoint_reg     <= '0;
            m_int_reg        <= '0;
            m_last_reg       <= '0;
            s_int_reg        <= '0;
            s_last_reg       <= '0;
            t_valid_reg      <= 1'b0;
        end else begin
            synced_reg       <= synced_next;
            final_target_reg <= final_target_next;
            setpoint_reg     <= setpoint_next;
            m_int_reg        <= m_int_next;
            m_last_reg       <= m_last_next;
            s_int_reg        <= s_int_next;
            s_last_reg       <= s_last_next;
            if (t_en) begin
                t_valid_reg <= in_valid_reg && synced_reg
                            && (in_item_reg.func == rmssp_pkg::FUNC_TICK);
            end
        end
        if (t_en) begin
            t_m_err_reg  <= m_err;
            t_m_int_reg  <= m_int_new;
            t_m_diff_reg <= m_diff;
            t_s_err_reg  <= s_err;
            t_s_int_reg  <= s_int_new;
            t_s_diff_reg <= s_diff;
            t_tpos_reg   <= tpos;
        end
    end

    // gain products
    logic signed [48:0] pm_e, ps_e;
    logic signed [26:0] pm_i;
    logic signed [25:0] ps_i;
    logic signed [49:0] pm_d, ps_d;
    logic signed [41:0] qm_e, qm_i, qm_d, qs_e, qs_i, qs_d;

    always_comb begin
        pm_e = 49'(t_m_err_reg) * 49'(cfg_master_kp_reg);
        pm_i = 27'(t_m_int_reg) * 27'(cfg_master_ki_reg);
        pm_d = 50'(t_m_diff_reg) * 50'(cfg_master_kd_reg);
        ps_e = 49'(t_s_err_reg) * 49'(cfg_slave_kp_reg);
        ps_i = 26'(t_s_int_reg) * 26'(cfg_slave_ki_reg);
        ps_d = 50'(t_s_diff_reg) * 50'(cfg_slave_kd_reg);
        qm_e = rmssp_pkg::q8_trunc(50'(pm_e));
        qm_i = rmssp_pkg::q8_trunc(50'(pm_i));
        qm_d = rmssp_pkg::q8_trunc(pm_d);
        qs_e = rmssp_pkg::q8_trunc(50'(ps_e));
        qs_i = rmssp_pkg::q8_trunc(50'(ps_i));
        qs_d = rmssp_pkg::q8_trunc(ps_d);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (p_en) begin
            p_valid_reg <= t_valid_reg;
        end
        if (p_en) begin
            p_m_e_reg  <= qm_e[40:0];
            p_m_i_reg  <= qm_i[18:0];
            p_m_d_reg  <= qm_d;
            p_s_e_reg  <= qs_e[40:0];
            p_s_i_reg  <= qs_i[17:0];
            p_s_d_reg  <= qs_d;
            p_tpos_reg <= t_tpos_reg;
        end
    end

    // sums, clamps and drive outputs
    logic signed [42:0] m_sum, s_sum, cl_pos, cl_neg;
    logic signed [8:0]  m_drive;
    logic signed [9:0]  m_wide, m_abs;
    logic signed [43:0] s_total;
    logic signed [15:0] s_drive;
    logic signed [16:0] s_wide, s_abs;

    always_comb begin
        m_sum  = 43'(p_m_e_reg) + 43'(p_m_i_reg) + 43'(p_m_d_reg);
        cl_pos = 43'(cfg_cruise_reg);
        cl_neg = -cl_pos;
        if (m_sum > cl_pos) begin
            m_drive = cl_pos[8:0];
        end else if (m_sum < cl_neg) begin
            m_drive = cl_neg[8:0];
        end else begin
            m_drive = m_sum[8:0];
        end
        m_wide = 10'(m_drive);
        m_abs  = m_wide[9] ? -m_wide : m_wide;

        s_sum   = 43'(p_s_e_reg) + 43'(p_s_i_reg) + 43'(p_s_d_reg);
        s_total = 44'(m_drive) + 44'(s_sum);
        if (s_total > rmssp_pkg::SLAVE_DRIVE_MAX) begin
            s_drive = 16'(rmssp_pkg::SLAVE_DRIVE_MAX);
        end else if (s_total < rmssp_pkg::SLAVE_DRIVE_MIN) begin
            s_drive = 16'(rmssp_pkg::SLAVE_DRIVE_MIN);
        end else begin
            s_drive = s_total[15:0];
        end
        s_wide = 17'(s_drive);
        s_abs  = s_wide[16] ? -s_wide : s_wide;

        m_data_next.master_drive  = m_drive;
        m_data_next.master_duty   = m_abs[7:0];
        m_data_next.master_dir    = m_drive[8];
        m_data_next.master_enable = m_drive != '0;
        m_data_next.slave_drive   = s_drive;
        if (m_drive == '0 && s_drive == '0) begin
            m_data_next.slave_duty   = '0;
            m_data_next.slave_dir    = 1'b0;
            m_data_next.slave_enable = 1'b0;
        end else begin
            m_data_next.slave_duty   = (s_abs > rmssp_pkg::DUTY_MAX)
                                     ? 8'(rmssp_pkg::DUTY_MAX) : s_abs[7:0];
            m_data_next.slave_dir    = s_drive[15] || (s_drive == '0);
            m_data_next.slave_enable = 1'b1;
        end
        m_data_next.ramp_target = p_tpos_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_en) begin
            m_valid_reg <= p_valid_reg;
        end
        if (out_en) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule
